// ===== design/mht_pkg.sv =====
package mht_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

endpackage

// ===== design/max_heap_table.sv =====
// channel | direction | ports
// input   | in        | s_valid, s_ready, s_func, s_value, s_index
// result  | out       | m_valid, m_ready, m_status, m_top_value, m_entry_count, m_read_value
//
// One transaction at a time. Insert/remove rebuild the heap through one
// memory with a registered read: each level of a sift-down steps through
// read node, left, right, compare and write node, write child, and each
// sift begins with a node-start step. Remove first moves the last entry
// into the removed slot. A read fetches the entry and then the top entry
// before the result; an error or the unused code fetches only the top entry.
// aresetn (synchronous, active low) empties the heap; entries are not cleared.
// s_ready is low while an operation runs or its result waits on m_ready.
module max_heap_table import mht_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [31:0] s_value,
    input  logic [5:0]         s_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_top_value,
    output logic [6:0]         m_entry_count,
    output logic signed [31:0] m_read_value
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RDLAST, S_WRREM, S_NODE, S_RDN, S_RDL, S_RDR,
        S_CMP, S_SWAP, S_RDTOP, S_TOP, S_RDRD, S_RD, S_OUT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    iter_reg;    // next sift start + 1
    logic [CNT_W:0]      node_reg;
    logic [CNT_W:0]      large_reg;
    logic signed [31:0]  nval_reg, bval_reg;
    logic [1:0]          func_reg;
    logic [5:0]          idx_reg;
    logic [1:0]          st_reg;
    logic signed [31:0]  top_reg, rdv_reg;
    logic                m_valid_reg;

    logic                we;
    logic [ADDR_W-1:0]   waddr, raddr;
    logic [31:0]         wdata, rdata;

    mht_store #(.DEPTH(CAPACITY), .ADDR_W(ADDR_W)) u_store (
        .aclk(aclk), .waddr(waddr), .we(we), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CNT_W:0] left_c, right_c;
    assign left_c  = {node_reg[CNT_W-1:0], 1'b1};
    assign right_c = left_c + 1'b1;

    // right child beats the best so far
    logic right_gt;
    assign right_gt = right_c < (CNT_W+1)'(count_reg) && $signed(rdata) > bval_reg;

    // memory port steering
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata;
        raddr = '0;
        case (state_reg)
            S_IDLE: begin
                we    = s_valid && s_ready && s_func == FUNC_INSERT
                        && count_reg < CNT_W'(CAPACITY);
                waddr = count_reg[ADDR_W-1:0];
                wdata = s_value;
                raddr = (s_func == FUNC_READ) ? ADDR_W'(s_index)
                                              : ADDR_W'(count_reg - 1'b1);
            end
            S_RDLAST: raddr = count_reg[ADDR_W-1:0];
            S_WRREM: begin
                we    = 1'b1;
                waddr = ADDR_W'(idx_reg);
                wdata = rdata;
            end
            S_RDN:  raddr = node_reg[ADDR_W-1:0];
            S_RDL:  raddr = left_c[ADDR_W-1:0];
            S_RDR:  raddr = right_c[ADDR_W-1:0];
            S_CMP: begin
                // write largest child into node
                we    = right_gt || large_reg != node_reg;
                waddr = node_reg[ADDR_W-1:0];
                wdata = right_gt ? rdata : bval_reg;
            end
            S_SWAP: begin
                we    = 1'b1;
                waddr = large_reg[ADDR_W-1:0];
                wdata = nval_reg;
            end
            S_RD:    raddr = ADDR_W'(idx_reg);
            S_RDTOP: raddr = '0;
            default: ;
        endcase
    end

    assign s_ready = state_reg == S_IDLE && !m_valid_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    func_reg <= s_func;
                    idx_reg  <= s_index;
                    st_reg   <= ST_OK;
                    rdv_reg  <= '0;
                    case (s_func)
                        FUNC_INSERT: begin
                            if (count_reg >= CNT_W'(CAPACITY)) begin
                                st_reg    <= ST_FULL;
                                state_reg <= S_RDTOP;
                            end else begin
                                count_reg <= count_reg + 1'b1;
                                iter_reg  <= (count_reg + 1'b1) >> 1;
                                state_reg <= S_NODE;
                            end
                        end
                        FUNC_REMOVE: begin
                            if ({1'b0, s_index} >= (CNT_W+1)'(count_reg)) begin
                                st_reg    <= ST_RANGE;
                                state_reg <= S_RDTOP;
                            end else begin
                                count_reg <= count_reg - 1'b1;
                                iter_reg  <= (count_reg - 1'b1) >> 1;
                                state_reg <= S_RDLAST;
                            end
                        end
                        FUNC_READ: begin
                            if ({1'b0, s_index} >= (CNT_W+1)'(count_reg)) begin
                                st_reg    <= ST_RANGE;
                                state_reg <= S_RDTOP;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end
                        default: state_reg <= S_RDTOP;
                    endcase
                end
                S_RDLAST: state_reg <= S_WRREM;
                S_WRREM:  state_reg <= S_NODE;
                S_NODE: begin
                    if (iter_reg == '0) begin
                        state_reg <= S_RDTOP;
                    end else begin
                        node_reg  <= (CNT_W+1)'(iter_reg - 1'b1);
                        iter_reg  <= iter_reg - 1'b1;
                        state_reg <= S_RDN;
                    end
                end
                S_RDN: state_reg <= S_RDL;
                S_RDL: begin
                    nval_reg  <= rdata;
                    bval_reg  <= rdata;
                    large_reg <= node_reg;
                    state_reg <= S_RDR;
                end
                S_RDR: begin
                    // left child result
                    if (left_c < (CNT_W+1)'(count_reg) && $signed(rdata) > bval_reg) begin
                        bval_reg  <= rdata;
                        large_reg <= left_c;
                    end
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    // right child result arrives now
                    if (right_gt) begin
                        bval_reg  <= rdata;
                        large_reg <= right_c;
                    end
                    state_reg <= S_SWAP;
                end
                S_SWAP: begin
                    if (large_reg == node_reg) begin
                        state_reg <= S_NODE;
                    end else begin
                        node_reg  <= large_reg;
                        state_reg <= S_RDN;
                    end
                end
                S_RDTOP: state_reg <= S_TOP;
                S_TOP: begin
                    top_reg   <= (count_reg != '0) ? $signed(rdata) : '0;
                    state_reg <= S_OUT;
                end
                S_RD: begin
                    state_reg <= S_RDRD;
                end
                S_RDRD: begin
                    rdv_reg   <= rdata;
                    state_reg <= S_RDTOP;
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = st_reg;
    assign m_top_value   = top_reg;
    assign m_entry_count = 7'(count_reg);
    assign m_read_value  = rdv_reg;

    // result only while idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == S_IDLE)
        else $error("result while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count over capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> m_entry_count == 7'(CAPACITY))
        else $error("full status with room");

endmodule

// ===== design/mht_store.sv =====
module mht_store import mht_pkg::*; #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              we,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
